// File: src/mhp_pkg.sv
// ----------------------------------------------------------------------------
// mhp_pkg
// Types, constants and helpers shared by the 802.15.4 MAC header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mhp_pkg;

  // frame control word fields
  localparam int unsigned FcTypeLsb    = 0;
  localparam int unsigned FcSecBit     = 3;
  localparam int unsigned FcPendBit    = 4;
  localparam int unsigned FcAckBit     = 5;
  localparam int unsigned FcCompBit    = 6;
  localparam int unsigned FcDstModeLsb = 10;
  localparam int unsigned FcSrcModeLsb = 14;

  // byte positions of the fixed part of the header
  localparam logic [4:0] PosFcLow  = 5'd0;
  localparam logic [4:0] PosFcHigh = 5'd1;
  localparam logic [4:0] PosDstPan = 5'd3;

  // control word, sequence number and destination pan
  localparam logic [4:0] FixedHdrLen = 5'd5;
  localparam logic [4:0] PanLen      = 5'd2;

  typedef enum logic [1:0] {
    ADDR_NONE     = 2'd0,
    ADDR_RESERVED = 2'd1,
    ADDR_SHORT    = 2'd2,
    ADDR_LONG     = 2'd3
  } addr_mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } byte_t;

  typedef struct packed {
    logic [2:0]  frame_type;
    logic        security_enabled;
    logic        frame_pending;
    logic        ack_request;
    logic [15:0] dest_pan;
    logic [63:0] dest_address;
    logic [3:0]  dest_address_len;
    logic [15:0] source_pan;
    logic [63:0] source_address;
    logic [3:0]  source_address_len;
    logic [4:0]  header_len;
    logic        truncated;
  } hdr_t;

  // address length in bytes for an addressing mode
  function automatic logic [3:0] mode_len(input logic [1:0] mode);
    logic [3:0] len;
    unique case (addr_mode_t'(mode))
      ADDR_SHORT: len = 4'd2;
      ADDR_LONG:  len = 4'd8;
      default:    len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: src/mac_header_parser_802154_unit.sv
// ----------------------------------------------------------------------------
// mac_header_parser_802154_unit
// Parses the MAC header of a received 802.15.4 frame, one byte per request.
// ----------------------------------------------------------------------------
//  channel  signals                           direction  payload
//  byte     byte_valid, byte_ready, byte_data  in         mhp_pkg::byte_t
//  hdr      hdr_valid, hdr_ready, hdr_data     out        mhp_pkg::hdr_t
//
//  one byte is taken every cycle while byte_ready is high; the header result is
//  registered and shows the cycle after the header's last byte (or early end)
//  unless out_reg is busy; out_reg plus a skid register hold up to two results,
//  so bytes flow while a result waits; byte_ready drops only when both are full.
//  rst is synchronous: frame state and both result valid flags are cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_header_parser_802154_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           byte_valid,
  output logic                byte_ready,
  input  wire mhp_pkg::byte_t byte_data,
  output logic                hdr_valid,
  input  wire logic           hdr_ready,
  output mhp_pkg::hdr_t       hdr_data
);

  // frame state
  logic [4:0]  pos;
  logic [15:0] ctrl;
  logic [15:0] dst_pan;
  logic [63:0] dst_addr;
  logic [15:0] src_pan;
  logic [63:0] src_addr;
  logic        done;

  logic [4:0]  pos_next;
  logic [15:0] ctrl_next;
  logic [15:0] dst_pan_next;
  logic [63:0] dst_addr_next;
  logic [15:0] src_pan_next;
  logic [63:0] src_addr_next;

  // result slots
  mhp_pkg::hdr_t out_reg;
  mhp_pkg::hdr_t skid_reg;
  logic          skid_valid;

  logic          accept;
  logic          take;
  logic          complete;
  logic          early_end;
  logic          fire;
  mhp_pkg::hdr_t result;

  logic [7:0]  b;
  logic [4:0]  off;
  logic [4:0]  off_addr;
  logic [4:0]  off_span;
  logic [4:0]  off_saddr;
  logic [4:0]  dlen;
  logic [4:0]  slen;
  logic        comp;
  logic [4:0]  dlen_new;
  logic [4:0]  slen_new;
  logic        comp_new;
  logic [4:0]  hlen_new;

  assign byte_ready = !skid_valid;
  assign accept     = byte_valid && byte_ready;
  assign take       = hdr_valid && hdr_ready;
  assign hdr_data   = out_reg;
  assign b          = byte_data.data_byte;

  // field layout from the stored control word (complete once pos >= 2)
  assign dlen = {1'b0, mhp_pkg::mode_len(ctrl[mhp_pkg::FcDstModeLsb +: 2])};
  assign slen = {1'b0, mhp_pkg::mode_len(ctrl[mhp_pkg::FcSrcModeLsb +: 2])};
  assign comp = ctrl[mhp_pkg::FcCompBit];

  assign off       = pos - mhp_pkg::PosDstPan;
  assign off_addr  = off - mhp_pkg::PanLen;
  assign off_span  = off_addr - dlen;
  assign off_saddr = comp ? off_span : off_span - mhp_pkg::PanLen;

  always_comb begin
    ctrl_next     = ctrl;
    dst_pan_next  = dst_pan;
    dst_addr_next = dst_addr;
    src_pan_next  = src_pan;
    src_addr_next = src_addr;
    pos_next      = pos + 5'd1;
    if (pos == mhp_pkg::PosFcLow) begin
      ctrl_next[7:0] = b;
    end else if (pos == mhp_pkg::PosFcHigh) begin
      ctrl_next[15:8] = b;
    end else if (pos >= mhp_pkg::PosDstPan) begin
      if (off < mhp_pkg::PanLen) begin
        dst_pan_next[off[0]*8 +: 8] = b;
      end else if (off_addr < dlen) begin
        dst_addr_next[off_addr[2:0]*8 +: 8] = b;
      end else if (!comp && off_span < mhp_pkg::PanLen) begin
        src_pan_next[off_span[0]*8 +: 8] = b;
      end else if (off_saddr < slen) begin
        src_addr_next[off_saddr[2:0]*8 +: 8] = b;
      end
    end
  end

  // header length from the control word as it stands after this byte
  assign dlen_new = {1'b0, mhp_pkg::mode_len(ctrl_next[mhp_pkg::FcDstModeLsb +: 2])};
  assign slen_new = {1'b0, mhp_pkg::mode_len(ctrl_next[mhp_pkg::FcSrcModeLsb +: 2])};
  assign comp_new = ctrl_next[mhp_pkg::FcCompBit];
  assign hlen_new = mhp_pkg::FixedHdrLen + dlen_new + slen_new
                    + (comp_new ? 5'd0 : mhp_pkg::PanLen);

  assign complete  = !done && (pos_next >= 5'd2) && (pos_next == hlen_new);
  assign early_end = !done && !complete && byte_data.frame_end;
  assign fire      = accept && (complete || early_end);

  always_comb begin
    result.frame_type         = ctrl_next[mhp_pkg::FcTypeLsb +: 3];
    result.security_enabled   = ctrl_next[mhp_pkg::FcSecBit];
    result.frame_pending      = ctrl_next[mhp_pkg::FcPendBit];
    result.ack_request        = ctrl_next[mhp_pkg::FcAckBit];
    result.dest_pan           = dst_pan_next;
    result.dest_address       = dst_addr_next;
    result.dest_address_len   = dlen_new[3:0];
    result.source_pan         = comp_new ? dst_pan_next : src_pan_next;
    result.source_address     = src_addr_next;
    result.source_address_len = slen_new[3:0];
    result.header_len         = pos_next;
    result.truncated          = early_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      ctrl     <= '0;
      dst_pan  <= '0;
      dst_addr <= '0;
      src_pan  <= '0;
      src_addr <= '0;
      done     <= 1'b0;
    end else if (accept) begin
      if (byte_data.frame_end) begin
        pos      <= '0;
        ctrl     <= '0;
        dst_pan  <= '0;
        dst_addr <= '0;
        src_pan  <= '0;
        src_addr <= '0;
        done     <= 1'b0;
      end else if (!done) begin
        pos      <= pos_next;
        ctrl     <= ctrl_next;
        dst_pan  <= dst_pan_next;
        dst_addr <= dst_addr_next;
        src_pan  <= src_pan_next;
        src_addr <= src_addr_next;
        done     <= complete;
      end
    end
  end

  // result slot control
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        hdr_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (fire) begin
      if (hdr_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        hdr_valid <= 1'b1;
      end
    end else if (take) begin
      hdr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_reg <= skid_reg;
      end
    end else if (fire) begin
      if (hdr_valid && !take) begin
        skid_reg <= result;
      end else begin
        out_reg <= result;
      end
    end
  end

endmodule

`default_nettype wire
